[rtl/tte_pkg.sv]
// Shared types, register codes and helper functions of the tensor transpose engine.
`default_nettype none

package tte_pkg;

   localparam int NUM_AXES  = 4;
   localparam int DATA_W    = 8;
   localparam int SIZE_W    = 13;
   localparam int IDX_W     = 12;
   localparam int RANK_W    = 3;
   localparam int PERM_W    = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RANK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_3 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PERM   = 3'd5;

   // Reset values
   localparam logic [RANK_W-1:0] RANK_RESET = 3'd4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd1;
   localparam logic [PERM_W-1:0] PERM_RESET = 8'd228;

   // Request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EMIT = 1'b1;

   typedef enum logic [1:0] {
      PH_COUNT,
      PH_REWIND,
      PH_STEP,
      PH_NONE
   } phase_type;

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] elem;
      logic                     last;
      logic                     error;
   } rsp_type;

   typedef struct packed {
      logic [RANK_W-1:0]                rank;
      logic [NUM_AXES-1:0][SIZE_W-1:0]  size;
      logic [PERM_W-1:0]                perm;
   } cfg_type;

   // Controller to datapath command
   typedef struct packed {
      logic      run;
      phase_type phase;
      logic [1:0] axis;
      logic      first;
   } cmd_type;

   // Extent clamped to 1..4096
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [SIZE_W-1:0] r;
      r = s;
      if (s == '0) begin
         r = 13'd1;
      end else if (s > SIZE_MAX) begin
         r = SIZE_MAX;
      end
      return r;
   endfunction

   // Rank clamped to 1..lim
   function automatic logic [RANK_W-1:0] eff_rank(input logic [RANK_W-1:0] rank,
                                                  input logic [RANK_W-1:0] lim);
      logic [RANK_W-1:0] r;
      r = rank;
      if (rank == '0) begin
         r = 3'd1;
      end else if (rank > lim) begin
         r = lim;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/tte_csr.sv]
// Configuration registers of the tensor transpose engine.
`default_nettype none

module tte_csr
   import tte_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_wdata,
   output cfg_type                   cfg,
   output logic                      cfg_wr
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; writes beyond the register list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      cfg_wr = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_RANK: begin
               cfg_in.rank = csr_wdata[RANK_W-1:0];
               cfg_wr      = 1'b1;
            end
            REG_SIZE_0: begin
               cfg_in.size[0] = csr_wdata;
               cfg_wr         = 1'b1;
            end
            REG_SIZE_1: begin
               cfg_in.size[1] = csr_wdata;
               cfg_wr         = 1'b1;
            end
            REG_SIZE_2: begin
               cfg_in.size[2] = csr_wdata;
               cfg_wr         = 1'b1;
            end
            REG_SIZE_3: begin
               cfg_in.size[3] = csr_wdata;
               cfg_wr         = 1'b1;
            end
            REG_PERM: begin
               cfg_in.perm = csr_wdata[PERM_W-1:0];
               cfg_wr      = 1'b1;
            end
            default: begin
               cfg_wr = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rank <= RANK_RESET;
         cfg_ff.size <= {NUM_AXES{SIZE_RESET}};
         cfg_ff.perm <= PERM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/tte_ctrl.sv]
// Controller: sequences the setup pass after reset and configuration writes.
`default_nettype none

module tte_ctrl
   import tte_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cfg_wr,
   output cmd_type   cmd
);

   typedef enum logic {
      ST_SETUP,
      ST_RUN
   } state_type;

   localparam logic [3:0] LAST_STEP = 4'd11;

   state_type  state_ff;
   state_type  state_in;
   logic [3:0] step_ff;
   logic [3:0] step_in;

   // Next state: a config write restarts the setup pass
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      if (cfg_wr) begin
         state_in = ST_SETUP;
         step_in  = '0;
      end else begin
         case (state_ff)
            ST_SETUP: begin
               if (step_ff == LAST_STEP) begin
                  state_in = ST_RUN;
                  step_in  = '0;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
            ST_RUN: begin
               step_in = '0;
            end
            default: begin
               state_in = ST_SETUP;
               step_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SETUP;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Command decode: four axes per phase
   always_comb begin
      cmd.run   = (state_ff == ST_RUN);
      cmd.first = (step_ff[1:0] == 2'd0);
      cmd.phase = PH_NONE;
      cmd.axis  = '0;
      if (state_ff == ST_SETUP) begin
         case (step_ff[3:2])
            2'd0: begin
               cmd.phase = PH_COUNT;
               cmd.axis  = 2'd3 - step_ff[1:0];
            end
            2'd1: begin
               cmd.phase = PH_REWIND;
               cmd.axis  = step_ff[1:0];
            end
            2'd2: begin
               cmd.phase = PH_STEP;
               cmd.axis  = 2'd3 - step_ff[1:0];
            end
            default: begin
               cmd.phase = PH_NONE;
               cmd.axis  = '0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[rtl/tte_dpath.sv]
// Datapath: element buffer, setup arithmetic, output index counters and result register.
`default_nettype none

module tte_dpath
   import tte_pkg::*;
#(
   parameter int CAPACITY = 4096,
   parameter int MAX_RANK = 4
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    cfg_wr,
   input  wire cmd_type cmd,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int SW = $clog2(CAPACITY + 2);
   localparam int PW = SW + SIZE_W;

   localparam logic [SW-1:0]     ACC_CAP  = SW'(CAPACITY);
   localparam logic [SW-1:0]     ACC_SAT  = SW'(CAPACITY + 1);
   localparam logic [PW-1:0]     PROD_CAP = PW'(CAPACITY);
   localparam logic [LW-1:0]     LOAD_CAP = LW'(CAPACITY);
   localparam logic [RANK_W-1:0] RANK_LIM =
      (MAX_RANK < NUM_AXES) ? RANK_W'(MAX_RANK) : RANK_W'(NUM_AXES);

   // Element buffer
   logic signed [DATA_W-1:0] mem [CAPACITY];

   // Setup results
   logic [SW-1:0]                acc_ff,    acc_in;
   logic [NUM_AXES-1:0][AW-1:0]  stride_ff, stride_in;
   logic [NUM_AXES-1:0][AW-1:0]  rewind_ff, rewind_in;
   logic [NUM_AXES-1:0][AW-1:0]  step_ff,   step_in;
   logic [AW-1:0]                tail_ff,   tail_in;

   // Run state
   logic [LW-1:0]                  lp_ff,  lp_in;
   logic [NUM_AXES-1:0][IDX_W-1:0] idx_ff, idx_in;
   logic [AW-1:0]                  pos_ff, pos_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           last_ff, last_in;
   logic                           err_ff,  err_in;
   logic signed [DATA_W-1:0]       rd_ff;

   logic [RANK_W-1:0]              rank_eff;
   logic [NUM_AXES-1:0][1:0]       axis_of;
   logic [NUM_AXES-1:0]            axis_ok;
   logic [NUM_AXES-1:0][IDX_W-1:0] last_idx;
   logic [NUM_AXES-1:0][AW-1:0]    ostride;

   logic [SW-1:0]     acc_src;
   logic [AW-1:0]     tail_src;
   logic [SW-1:0]     mul_a;
   logic [SIZE_W-1:0] mul_b;
   logic [PW-1:0]     prod;

   logic       count_err;
   logic       accept, is_load, is_emit, load_ok;
   logic       found;
   logic [1:0] k;

   // Axis map: extent per output axis, and the input stride each output axis walks.
   // A repeated input axis only moves with the highest output axis that names it.
   always_comb begin
      rank_eff = eff_rank(cfg.rank, RANK_LIM);
      for (int d = 0; d < NUM_AXES; d++) begin
         axis_of[d] = cfg.perm[2*d +: 2];
         axis_ok[d] = (RANK_W'(d) < rank_eff) && ({1'b0, axis_of[d]} < rank_eff);
         last_idx[d] = axis_ok[d] ?
            IDX_W'(eff_size(cfg.size[axis_of[d]]) - 13'd1) : '0;
      end
      for (int d = 0; d < NUM_AXES; d++) begin
         ostride[d] = axis_ok[d] ? stride_ff[axis_of[d]] : '0;
         for (int e = d + 1; e < NUM_AXES; e++) begin
            if (axis_ok[e] && (axis_of[e] == axis_of[d])) begin
               ostride[d] = '0;
            end
         end
      end
   end

   // Shared setup multiplier
   always_comb begin
      acc_src  = cmd.first ? SW'(1) : acc_ff;
      tail_src = cmd.first ? '0 : tail_ff;
      case (cmd.phase)
         PH_COUNT: begin
            mul_a = acc_src;
            mul_b = eff_size(cfg.size[cmd.axis]);
         end
         PH_REWIND: begin
            mul_a = SW'(ostride[cmd.axis]);
            mul_b = {1'b0, last_idx[cmd.axis]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = PW'(mul_a) * PW'(mul_b);
   end

   // Setup pass: strides and saturating element count, rewind per axis, then
   // the position step taken when each axis increments and inner axes wrap
   always_comb begin
      acc_in    = acc_ff;
      stride_in = stride_ff;
      rewind_in = rewind_ff;
      step_in   = step_ff;
      tail_in   = tail_ff;
      case (cmd.phase)
         PH_COUNT: begin
            if ({1'b0, cmd.axis} < rank_eff) begin
               stride_in[cmd.axis] = acc_src[AW-1:0];
               acc_in = (prod > PROD_CAP) ? ACC_SAT : prod[SW-1:0];
            end else begin
               stride_in[cmd.axis] = '0;
               acc_in = acc_src;
            end
         end
         PH_REWIND: begin
            rewind_in[cmd.axis] = prod[AW-1:0];
         end
         PH_STEP: begin
            step_in[cmd.axis] = ostride[cmd.axis] - tail_src;
            tail_in = tail_src + rewind_ff[cmd.axis];
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      stride_ff <= stride_in;
      rewind_ff <= rewind_in;
      step_ff   <= step_in;
      tail_ff   <= tail_in;
   end

   assign count_err = (acc_ff > ACC_CAP);

   // Handshake: outside the setup pass, take a transfer whenever the result register can be freed
   assign req_ready = cmd.run && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign is_load   = accept && (req_data.func == FUNC_LOAD);
   assign is_emit   = accept && (req_data.func == FUNC_EMIT);
   assign load_ok   = (lp_ff < LOAD_CAP);

   // Innermost output axis that has not reached its last index
   always_comb begin
      found = 1'b0;
      k     = '0;
      for (int d = 0; d < NUM_AXES; d++) begin
         if ((RANK_W'(d) < rank_eff) && (idx_ff[d] != last_idx[d])) begin
            found = 1'b1;
            k     = 2'(d);
         end
      end
   end

   // Counters and result register
   always_comb begin
      lp_in        = lp_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      if (cfg_wr) begin
         lp_in  = '0;
         idx_in = '0;
         pos_in = '0;
      end else if (is_load && load_ok) begin
         lp_in = lp_ff + LW'(1);
      end else if (is_emit && !count_err) begin
         if (!found) begin
            lp_in  = '0;
            idx_in = '0;
            pos_in = '0;
         end else begin
            for (int d = 0; d < NUM_AXES; d++) begin
               if (2'(d) == k) begin
                  idx_in[d] = idx_ff[d] + 12'd1;
               end else if (2'(d) > k) begin
                  idx_in[d] = '0;
               end
            end
            pos_in = pos_ff + step_ff[k];
         end
      end
      if (is_emit) begin
         rsp_valid_in = 1'b1;
         last_in      = !count_err && !found;
         err_in       = count_err;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff        <= '0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lp_ff        <= lp_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   // Buffer write on load, registered read on emit
   always_ff @(posedge clock) begin
      if (is_load && load_ok) begin
         mem[lp_ff[AW-1:0]] <= req_data.value;
      end
      if (is_emit) begin
         rd_ff <= mem[pos_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data.elem  = err_ff ? '0 : rd_ff;
   assign rsp_data.last  = last_ff;
   assign rsp_data.error = err_ff;

endmodule

`default_nettype wire

[rtl/tensor_transpose_engine_core.sv]
// Top level of the tensor transpose engine: 4-D axis permutation of signed bytes.
//
//  Port group   Direction  Handshake            Payload
//  req_*        in         req_valid/req_ready  req_data : func, value
//  rsp_*        out        rsp_valid/rsp_ready  rsp_data : elem, last, error
//  csr_*        in         csr_we (no wait)     csr_index, csr_wdata
//
// One transfer per cycle on req_* while rsp_ready is high, outside the setup pass;
// an emit returns its result the cycle after acceptance from the registered buffer read.
// After reset and after each write to a defined register a setup pass runs through the
// shared multiplier (strides, element count, per-axis steps); req_ready is low meanwhile.
// Reset is synchronous and clears the load pointer, index counters and result valid.
// While rsp_valid is high and rsp_ready low, the result holds and no request is taken.
`default_nettype none

module tensor_transpose_engine_core
   import tte_pkg::*;
#(
   parameter int CAPACITY = 4096,
   parameter int MAX_RANK = 4
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SIZE_W-1:0]    csr_wdata
);

   cfg_type cfg;
   logic    cfg_wr;
   cmd_type cmd;

   tte_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .cfg_wr    (cfg_wr)
   );

   tte_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .cfg_wr (cfg_wr),
      .cmd    (cmd)
   );

   tte_dpath #(
      .CAPACITY (CAPACITY),
      .MAX_RANK (MAX_RANK)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cfg_wr    (cfg_wr),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A register write forces a setup pass before the next transfer
   a_setup_after_write: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !req_ready)
      else $error("request taken right after a register write");

   // An error result never marks the last element
   a_error_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error |-> !rsp_data.last)
      else $error("error result flagged as last");

   // A new result only follows an accepted emit
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |->
         $past(req_valid && req_ready && (req_data.func == FUNC_EMIT)))
      else $error("result without an accepted emit");

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench of the tensor transpose engine core: directed table, random phases.
`timescale 1ns / 1ps

module tb;
   import tte_pkg::*;

   localparam int CAPACITY   = 4096;
   localparam int MAX_RANK   = 4;
   localparam int SETTLE_CYC = 4;
   localparam int MAX_IDLE   = 6;
   localparam int RAND_ITEMS = 760;
   localparam int LONG_HOLD  = 200;
   localparam int FULL_SIDE  = 16;

   // Indexes past the register list: writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [SIZE_W-1:0]    wdata;
      req_type              item;
      bit                   typed;
      rsp_type              want;
   } plan_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;

   tensor_transpose_engine_core #(.CAPACITY(CAPACITY), .MAX_RANK(MAX_RANK)) DUT (.*);

   // Shadow copy of the engine state
   logic signed [DATA_W-1:0] shadow_mem [CAPACITY];
   bit                       mem_loaded [CAPACITY];
   int unsigned              load_ptr;
   int unsigned              out_idx [NUM_AXES];
   cfg_type                  shadow_cfg;

   rsp_type      awaited_elems [$];
   plan_row_type plan [$];
   int unsigned  failures;
   int unsigned  results_seen;
   int unsigned  items_sent;
   int unsigned  loads_sent;
   int unsigned  emits_sent;
   int unsigned  writes_done;
   int unsigned  capacity_errs;
   int unsigned  tensor_ends;
   bit           tx_burst;
   bit           backlog_req;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_position();
      load_ptr = 0;
      foreach (out_idx[d]) out_idx[d] = 0;
   endfunction

   function automatic int unsigned rank_used();
      int unsigned r;
      r = shadow_cfg.rank;
      if (r == 0) r = 1;
      if (r > MAX_RANK) r = MAX_RANK;
      return r;
   endfunction

   function automatic int unsigned extent(input int unsigned a);
      int unsigned s;
      s = shadow_cfg.size[a];
      if (s == 0) s = 1;
      if (s > 4096) s = 4096;
      return s;
   endfunction

   function automatic longint unsigned element_count();
      longint unsigned n;
      n = 1;
      for (int unsigned a = 0; a < rank_used(); a++) n *= extent(a);
      return n;
   endfunction

   // Buffer address of the next output element; only valid while the count fits
   function automatic int unsigned source_pos();
      int unsigned     r;
      int unsigned     ax;
      longint unsigned pos;
      longint unsigned stride;
      int unsigned     in_idx [NUM_AXES];
      r = rank_used();
      foreach (in_idx[a]) in_idx[a] = 0;
      // highest output axis naming an input axis wins
      for (int unsigned d = 0; d < r; d++) begin
         ax = shadow_cfg.perm[2*d +: 2];
         if (ax < r) in_idx[ax] = out_idx[d];
      end
      pos    = 0;
      stride = 1;
      for (int a = int'(r) - 1; a >= 0; a--) begin
         pos    += in_idx[a] * stride;
         stride *= extent(a);
      end
      return int'(pos);
   endfunction

   function automatic bit emit_readable();
      if (element_count() > CAPACITY) return 1'b1;
      return mem_loaded[source_pos()];
   endfunction

   // Advances the shadow state by one transfer; returns 1 when a result is due
   function automatic bit transpose_step(input req_type it, output rsp_type res);
      int unsigned r;
      int unsigned ax;
      int unsigned ext [NUM_AXES];
      bit          wrapped;
      res = '0;
      if (it.func == FUNC_LOAD) begin
         if (load_ptr < CAPACITY) begin
            shadow_mem[load_ptr] = it.value;
            mem_loaded[load_ptr] = 1'b1;
            load_ptr++;
         end
         return 1'b0;
      end
      if (element_count() > CAPACITY) begin
         res.error = 1'b1;
         return 1'b1;
      end
      r = rank_used();
      res.elem = shadow_mem[source_pos()];
      for (int unsigned d = 0; d < r; d++) begin
         ax     = shadow_cfg.perm[2*d +: 2];
         ext[d] = (ax < r) ? extent(ax) : 1;
      end
      // odometer over the output axes, innermost first
      wrapped = 1'b1;
      for (int d = int'(r) - 1; d >= 0; d--) begin
         out_idx[d]++;
         if (out_idx[d] < ext[d]) begin
            wrapped = 1'b0;
            break;
         end
         out_idx[d] = 0;
      end
      if (wrapped) begin
         clear_position();
         res.last = 1'b1;
      end
      return 1'b1;
   endfunction

   function automatic void shadow_write(input logic [CSR_IDX_W-1:0] idx,
                                        input logic [SIZE_W-1:0] data);
      case (idx)
         REG_RANK:   shadow_cfg.rank    = data[RANK_W-1:0];
         REG_SIZE_0: shadow_cfg.size[0] = data;
         REG_SIZE_1: shadow_cfg.size[1] = data;
         REG_SIZE_2: shadow_cfg.size[2] = data;
         REG_SIZE_3: shadow_cfg.size[3] = data;
         REG_PERM:   shadow_cfg.perm    = data[PERM_W-1:0];
         default:    return;
      endcase
      clear_position();
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic signed [DATA_W-1:0] rand_byte();
      return DATA_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (p < 65) return SIZE_W'($urandom_range(0, 3));
      if (p < 87) return SIZE_W'($urandom_range(4, 8));
      if (p < 94) return SIZE_W'($urandom_range(4096, 8191));
      return SIZE_W'($urandom_range(0, 8191));
   endfunction

   function automatic plan_row_type write_row(input logic [CSR_IDX_W-1:0] idx,
                                              input logic [SIZE_W-1:0] data);
      plan_row_type row;
      row       = '{kind: ROW_WRITE, default: '0};
      row.idx   = idx;
      row.wdata = data;
      return row;
   endfunction

   function automatic plan_row_type item_row(input logic func, input logic [DATA_W-1:0] value,
                                             input bit typed = 1'b0,
                                             input logic [DATA_W-1:0] elem = '0,
                                             input logic last = 1'b0,
                                             input logic error = 1'b0);
      plan_row_type row;
      row            = '{kind: ROW_ITEM, default: '0};
      row.item.func  = func;
      row.item.value = value;
      row.typed      = typed;
      row.want.elem  = elem;
      row.want.last  = last;
      row.want.error = error;
      return row;
   endfunction

   // One request transfer; the expectation is queued before the item is offered
   task automatic push_item(input req_type it, input bit typed, input rsp_type want);
      rsp_type     res;
      bit          due;
      int unsigned gap;
      due = transpose_step(it, res);
      if (due) begin
         if (typed) res = want;
         awaited_elems.push_back(res);
         if (res.error) capacity_errs++;
         if (res.last) tensor_ends++;
      end
      if (it.func == FUNC_LOAD) loads_sent++;
      else emits_sent++;
      items_sent++;
      gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Emits that would read a never-loaded entry become loads
   task automatic send_op(input logic func, input logic signed [DATA_W-1:0] value);
      req_type it;
      it.func  = func;
      it.value = value;
      if (func == FUNC_EMIT && !emit_readable()) it.func = FUNC_LOAD;
      push_item(it, 1'b0, '0);
   endtask

   // Stop offering, wait out every owed result and the load pipeline
   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_elems.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
      shadow_write(idx, data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      writes_done++;
   endtask

   task automatic random_setup();
      logic [SIZE_W-1:0] data;
      bit                any;
      drain();
      any = 1'b0;
      if ($urandom_range(0, 9) == 0) csr_write(REG_UNUSED_LO, SIZE_W'($urandom_range(0, 8191)));
      if ($urandom_range(0, 2) != 0) begin
         // junk in the upper data bits must be ignored
         data        = SIZE_W'($urandom_range(0, 8191));
         data[2:0]   = 3'($urandom_range(0, 7));
         csr_write(REG_RANK, data);
         any = 1'b1;
      end
      if ($urandom_range(0, 2) != 0) begin csr_write(REG_SIZE_0, pick_size()); any = 1'b1; end
      if ($urandom_range(0, 2) != 0) begin csr_write(REG_SIZE_1, pick_size()); any = 1'b1; end
      if ($urandom_range(0, 2) != 0) begin csr_write(REG_SIZE_2, pick_size()); any = 1'b1; end
      if ($urandom_range(0, 2) != 0) begin csr_write(REG_SIZE_3, pick_size()); any = 1'b1; end
      if (!any || $urandom_range(0, 2) != 0) csr_write(REG_PERM, SIZE_W'($urandom_range(0, 8191)));
      if ($urandom_range(0, 9) == 0) csr_write(REG_UNUSED_HI, SIZE_W'($urandom_range(0, 8191)));
   endtask

   // ---------------------------------------------------------------- result side

   // Receiver: per-transfer stall, burst stretches, and long hold-offs on request
   initial begin
      int unsigned stall;
      int unsigned taken;
      bit          rx_burst;
      taken    = 0;
      rx_burst = 1'b0;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
         if (backlog_req) begin
            backlog_req = 1'b0;
            stall       = LONG_HOLD;
         end else begin
            stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   // Checker: every result transfer against the oldest owed result
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (awaited_elems.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("result %0d not owed: elem=%0d last=%0b error=%0b", results_seen,
                        rsp_data.elem, rsp_data.last, rsp_data.error);
         end else begin
            want = awaited_elems.pop_front();
            if (rsp_data.elem !== want.elem || rsp_data.last !== want.last ||
                rsp_data.error !== want.error) begin
               failures++;
               if (failures <= 10) begin
                  $display("result %0d: expected elem=%0d last=%0b error=%0b",
                           results_seen, want.elem, want.last, want.error);
                  $display("           got      elem=%0d last=%0b error=%0b",
                           rsp_data.elem, rsp_data.last, rsp_data.error);
               end
            end
         end
      end
   end

   // Run limit
   initial begin
      repeat (1_000_000) @(posedge clock);
      $display("run limit reached with %0d results still owed", awaited_elems.size());
      $display("tb NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      int unsigned     rand_base;
      int unsigned     stop_at;
      int unsigned     wait_cyc;
      longint unsigned total;
      bit              mid_hold_done;

      failures      = 0;
      results_seen  = 0;
      items_sent    = 0;
      loads_sent    = 0;
      emits_sent    = 0;
      writes_done   = 0;
      capacity_errs = 0;
      tensor_ends   = 0;
      tx_burst      = 1'b0;
      backlog_req   = 1'b0;
      mid_hold_done = 1'b0;

      shadow_cfg.rank = RANK_RESET;
      for (int a = 0; a < NUM_AXES; a++) shadow_cfg.size[a] = SIZE_RESET;
      shadow_cfg.perm = PERM_RESET;
      clear_position();

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      // reset shape is one element: byte extremes, each emit ends the tensor
      plan.push_back(item_row(FUNC_LOAD, 8'h80));
      plan.push_back(item_row(FUNC_EMIT, 8'h00, 1'b1, 8'h80, 1'b1, 1'b0));
      plan.push_back(item_row(FUNC_LOAD, 8'h7F));
      plan.push_back(item_row(FUNC_EMIT, 8'hFF, 1'b1, 8'h7F, 1'b1, 1'b0));
      // oversized extent clamps to 4096, axis one doubles it past capacity
      plan.push_back(write_row(REG_SIZE_0, 13'h1FFF));
      plan.push_back(write_row(REG_SIZE_1, 13'd2));
      plan.push_back(item_row(FUNC_EMIT, 8'h00, 1'b1, 8'h00, 1'b0, 1'b1));
      plan.push_back(item_row(FUNC_LOAD, 8'h01));
      // zero extent reads as one: count sits exactly at capacity
      plan.push_back(write_row(REG_SIZE_1, 13'd0));
      plan.push_back(item_row(FUNC_EMIT, 8'h00, 1'b1, 8'h01, 1'b0, 1'b0));
      // rank two with junk upper bits, 2x3 input, axes swapped
      plan.push_back(write_row(REG_RANK, 13'h1FFA));
      plan.push_back(write_row(REG_SIZE_0, 13'd2));
      plan.push_back(write_row(REG_SIZE_1, 13'd3));
      plan.push_back(write_row(REG_PERM, 13'h1FE1));
      plan.push_back(item_row(FUNC_LOAD, 8'h0A));
      plan.push_back(item_row(FUNC_LOAD, 8'hF5));
      plan.push_back(item_row(FUNC_LOAD, 8'h0C));
      plan.push_back(item_row(FUNC_LOAD, 8'hF3));
      plan.push_back(item_row(FUNC_LOAD, 8'h0E));
      plan.push_back(item_row(FUNC_LOAD, 8'hF1));
      repeat (6) plan.push_back(item_row(FUNC_EMIT, 8'h55));
      // rank above range clamps to four, all axes reversed; a stray write mid-tensor
      plan.push_back(write_row(REG_RANK, 13'd7));
      plan.push_back(write_row(REG_PERM, 13'h001B));
      repeat (3) plan.push_back(item_row(FUNC_EMIT, 8'hAA));
      plan.push_back(write_row(REG_UNUSED_LO, 13'h1555));
      repeat (3) plan.push_back(item_row(FUNC_EMIT, 8'h33));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            drain();
            csr_write(plan[i].idx, plan[i].wdata);
         end else begin
            push_item(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      // Random phases: mostly load-then-emit tensors, the rest mixed traffic
      rand_base = items_sent;
      while (items_sent - rand_base < RAND_ITEMS) begin
         random_setup();
         tx_burst = ($urandom_range(0, 3) == 0);
         if (!mid_hold_done && items_sent - rand_base > 300) begin
            backlog_req   = 1'b1;
            mid_hold_done = 1'b1;
         end
         total = element_count();
         if (total <= 64 && $urandom_range(0, 4) != 0) begin
            repeat (total + $urandom_range(0, 2)) send_op(FUNC_LOAD, rand_byte());
            stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total) : total;
            repeat ($urandom_range(1, 2)) begin
               for (int unsigned k = 0; k < stop_at; k++) begin
                  if ($urandom_range(0, 40) == 0) drain();
                  send_op(FUNC_EMIT, rand_byte());
               end
            end
         end else begin
            repeat ($urandom_range(4, 24))
               send_op(($urandom_range(0, 1) != 0) ? FUNC_EMIT : FUNC_LOAD, rand_byte());
         end
      end

      // Square tensor swapped, loaded whole, then streamed out under a receiver backlog
      drain();
      tx_burst = 1'b0;
      csr_write(REG_RANK, 13'h0AAA);
      csr_write(REG_SIZE_0, 13'(FULL_SIDE));
      csr_write(REG_SIZE_1, 13'(FULL_SIDE));
      csr_write(REG_PERM, 13'h15E1);
      repeat (FULL_SIDE * FULL_SIDE) send_op(FUNC_LOAD, rand_byte());
      backlog_req = 1'b1;
      repeat (FULL_SIDE * FULL_SIDE) send_op(FUNC_EMIT, rand_byte());

      // Wind down
      req_valid <= 1'b0;
      for (wait_cyc = 0; wait_cyc < 20000 && awaited_elems.size() != 0; wait_cyc++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (awaited_elems.size() != 0) begin
         failures++;
         $display("%0d results never arrived", awaited_elems.size());
      end

      $display("covered %0d loads and %0d emits over %0d register writes",
               loads_sent, emits_sent, writes_done);
      $display("checked %0d results: %0d over capacity, %0d tensor ends, %0d mismatches",
               results_seen, capacity_errs, tensor_ends, failures);
      if (failures == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/tte_pkg.sv
rtl/tte_csr.sv
rtl/tte_ctrl.sv
rtl/tte_dpath.sv
rtl/tensor_transpose_engine_core.sv
test/tb.sv
